// File: src/tmd_pkg.sv
// Shared types, constants and helper functions for the TSC mass deposit block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tmd_pkg;

    // Default geometry and queue sizing.
    localparam int CELLS_X_DEF = 20;
    localparam int CELLS_Y_DEF = 20;
    localparam int CELLS_Z_DEF = 20;
    localparam int GHOST_DEF   = 2;
    localparam int Q_DEPTH_DEF = 4;

    // Base cell index width, enough for the largest supported array.
    localparam int BASE_W = 10;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLOCK  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_X = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Y = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Z = 4'd7;

    localparam int AMT_W = 48;
    localparam logic [AMT_W-1:0] AMT_MAX = '1;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [31:0] INV_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]       dims;
        logic [15:0]      target;
        logic [2:0][31:0] origin;
        logic [2:0][31:0] inv;
    } t_cfg;

    // One classified particle: base cells and the three weights per axis.
    typedef struct packed {
        logic                   skip;
        logic                   eob;
        logic [31:0]            mass;
        logic [2:0][BASE_W-1:0] base;
        logic [2:0][2:0][15:0]  w;
    } t_job;

    // Per-cell side data that travels with the amount through the back end.
    typedef struct packed {
        logic [4:0] ci;
        logic [4:0] cj;
        logic [4:0] ck;
        logic       skip;
        logic       last;
        logic       bdone;
    } t_meta;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic f_multi(input logic [1:0] dims);
        return dims[1];
    endfunction

    function automatic logic f_three(input logic [1:0] dims);
        return dims == 2'd3;
    endfunction

    // TSC weight of a Q.16 offset magnitude, returned in Q.16.
    function automatic logic [15:0] f_tsc_weight(input logic [17:0] u);
        logic [29:0] sq_in;
        logic [16:0] d;
        logic [33:0] sq_out;
        logic [31:0] w32;
        sq_in  = 30'(u[14:0]) * 30'(u[14:0]);
        d      = 17'(18'd98304 - u);
        sq_out = 34'(d) * 34'(d);
        if (u < 18'd32768) begin
            w32 = 32'hC000_0000 - 32'(sq_in);
        end else if (u < 18'd98304) begin
            w32 = sq_out[32:1];
        end else begin
            w32 = 32'd0;
        end
        return w32[31:16];
    endfunction

endpackage

`default_nettype wire

// File: src/tmd_queue.sv
// Short job queue between the classifying front end and the deposit back end.
// Depends on tmd_pkg for the job and status types.
`default_nettype none

module tmd_queue import tmd_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    input  wire logic   i_pop,
    output t_job        o_head,
    output t_qstat      o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// File: src/tmd_front.sv
// Front end: locates a particle on each axis and computes its TSC weights.
// Seven-stage pipeline, one item per cycle; depends on tmd_pkg.
`default_nettype none

module tmd_front import tmd_pkg::*; #(
    parameter int CELLS_X = CELLS_X_DEF,
    parameter int CELLS_Y = CELLS_Y_DEF,
    parameter int CELLS_Z = CELLS_Z_DEF,
    parameter int GHOST   = GHOST_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_take,
    input  wire logic        [15:0] i_block_gid,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic        [31:0] i_mass,
    input  wire logic               i_end_of_batch,
    output logic                    o_job_valid,
    output t_job                    o_job
);

    localparam int NCELLS [3] = '{CELLS_X, CELLS_Y, CELLS_Z};
    localparam logic [63:0] GHOST_Q = {32'(GHOST), 32'd0};
    localparam logic [64:0] MAG_LIM = 65'd1 << 62;
    localparam logic signed [63:0] XI_LIM = 64'sd4294967296000000000;

    typedef struct packed {
        logic [31:0] mass;
        logic        eob;
        logic        gid_ok;
    } t_side;

    logic [6:1] r_v;
    logic       r_job_v;
    t_side      r_side [6];
    t_job       r_job;

    logic [31:0]       pos [3];
    logic [32:0]       s1_diff [3];
    logic [32:0]       s1_dmag [3];

    logic [32:0]       r1_dmag [3];
    logic              r1_neg  [3];
    logic [64:0]       r2_mag  [3];
    logic              r2_neg  [3];
    logic [63:0]       r3_xi   [3];
    logic              r3_big  [3];
    logic signed [31:0] r4_i0  [3];
    logic [35:0]       r4_xlo  [3];
    logic              r4_bad  [3];
    logic [35:0]       r5_frac [3];
    logic [BASE_W-1:0] r5_base [3];
    logic              r5_fail [3];
    logic [17:0]       r6_u    [3][3];
    logic [BASE_W-1:0] r6_base [3];
    logic              r6_fail [3];

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s1_diff[a] = {pos[a][31], pos[a]} - {i_cfg.origin[a][31], i_cfg.origin[a]};
            s1_dmag[a] = s1_diff[a][32] ? (~s1_diff[a] + 33'd1) : s1_diff[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_job_v <= 1'b0;
        end else begin
            r_v     <= {r_v[5:1], i_take};
            r_job_v <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] smag;
        logic [63:0] xm1;
        logic [63:0] xm2;
        logic [35:0] g;
        logic [35:0] gabs;
        logic        ok;
        r_side[0].mass   <= i_mass;
        r_side[0].eob    <= i_end_of_batch;
        r_side[0].gid_ok <= (i_block_gid == i_cfg.target);
        for (int s = 1; s < 6; s++) begin
            r_side[s] <= r_side[s-1];
        end
        for (int a = 0; a < 3; a++) begin
            // Stage 1: offset from the block origin, as sign and magnitude.
            r1_dmag[a] <= s1_dmag[a];
            r1_neg[a]  <= s1_diff[a][32];
            // Stage 2: scale by the inverse spacing.
            r2_mag[a]  <= 65'(r1_dmag[a]) * 65'(i_cfg.inv[a]);
            r2_neg[a]  <= r1_neg[a];
            // Stage 3: signed fractional index with the ghost offset.
            smag       = r2_mag[a][63:0];
            r3_big[a]  <= (r2_mag[a] > MAG_LIM);
            r3_xi[a]   <= (r2_neg[a] ? (~smag + 64'd1) : smag) + GHOST_Q;
            // Stage 4: range guard and base index truncated toward zero.
            xm1        = r3_xi[a] - 64'd1;
            xm2        = r3_xi[a] - 64'h1_0000_0000;
            r4_bad[a]  <= r3_big[a] || !(($signed(r3_xi[a]) > -XI_LIM) &&
                                         ($signed(r3_xi[a]) < XI_LIM));
            r4_i0[a]   <= $signed(xm2[63] ? xm1[63:32] : xm2[63:32]);
            r4_xlo[a]  <= r3_xi[a][35:0];
            // Stage 5: footprint check and cloud offset.
            r5_fail[a] <= r4_bad[a] || r4_i0[a][31] ||
                          ({1'b0, r4_i0[a]} + 33'd2 >= 33'(NCELLS[a]));
            r5_frac[a] <= {r4_i0[a][3:0], 32'd0} + 36'h0_8000_0000 - r4_xlo[a];
            r5_base[a] <= r4_i0[a][BASE_W-1:0];
            // Stage 6: weight argument magnitudes for the three cells.
            for (int n = 0; n < 3; n++) begin
                g    = r5_frac[a] + (36'(n) << 32);
                gabs = g[35] ? (~g + 36'd1) : g;
                r6_u[a][n] <= gabs[33:16];
            end
            r6_base[a] <= r5_base[a];
            r6_fail[a] <= r5_fail[a];
        end
        // Stage 7: weights and the accept/skip decision.
        ok = r_side[5].gid_ok && !r6_fail[0] &&
             (!f_multi(i_cfg.dims) || !r6_fail[1]) &&
             (!f_three(i_cfg.dims) || !r6_fail[2]);
        r_job.skip <= !ok;
        r_job.eob  <= r_side[5].eob;
        r_job.mass <= r_side[5].mass;
        for (int a = 0; a < 3; a++) begin
            r_job.base[a] <= r6_base[a];
            for (int n = 0; n < 3; n++) begin
                r_job.w[a][n] <= f_tsc_weight(r6_u[a][n]);
            end
        end
    end

    assign o_job_valid = r_job_v;
    assign o_job       = r_job;

endmodule

`default_nettype wire

// File: src/tmd_back.sv
// Back end: walks the cells of each job and forms the saturating amounts.
// Eight-stage multiply pipeline ending in the result register; depends on tmd_pkg.
`default_nettype none

module tmd_back import tmd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_job    i_head,
    input  wire logic    i_q_empty,
    output logic         o_q_pop,
    input  wire logic    pop,
    output logic         empty,
    output logic [4:0]   o_cell_i,
    output logic [4:0]   o_cell_j,
    output logic [4:0]   o_cell_k,
    output logic [47:0]  o_amount,
    output logic         o_skipped,
    output logic         o_last_of_run,
    output logic         o_batch_done
);

    logic        multi, three, en, issue, last;
    logic [1:0]  r_ii, r_jj, r_kk, n_ii, n_jj, n_kk;
    logic [8:1]  r_bv;
    t_meta       r_meta [8];
    t_meta       iss_meta;
    logic [16:0] w1, w2, w3;
    logic [31:0] inv_y, inv_z;

    logic [31:0] r1_p, r2_p, r3_p;
    logic [16:0] r1_w2, r1_w3, r2_w3;
    logic [47:0] r4_a, r6_a;
    logic [63:0] r5_lo, r7_lo;
    logic [15:0] r5_hi, r7_hi;
    logic        r6_sat, r7_sat;
    logic [47:0] r8_amt;

    logic [48:0] m1, m2, m3;
    logic [63:0] m4;
    logic [47:0] hp6, hp8;
    logic [79:0] f6, f8;

    assign multi = f_multi(i_cfg.dims);
    assign three = f_three(i_cfg.dims);
    // Inactive axes scale by exactly one.
    assign inv_y = multi ? i_cfg.inv[1] : INV_RESET;
    assign inv_z = three ? i_cfg.inv[2] : INV_RESET;

    // The whole pipeline moves whenever the result register can take a value.
    assign en    = !r_bv[8] || pop;
    assign issue = en && !i_q_empty;

    always_comb begin
        last = i_head.skip ||
               ((r_ii == 2'd2) && (!multi || r_jj == 2'd2) && (!three || r_kk == 2'd2));
        n_ii = r_ii;
        n_jj = r_jj;
        n_kk = r_kk;
        if (issue) begin
            if (last) begin
                n_ii = '0;
                n_jj = '0;
                n_kk = '0;
            end else if (r_ii != 2'd2) begin
                n_ii = r_ii + 2'd1;
            end else if (multi && r_jj != 2'd2) begin
                n_ii = '0;
                n_jj = r_jj + 2'd1;
            end else begin
                n_ii = '0;
                n_jj = '0;
                n_kk = r_kk + 2'd1;
            end
        end
        iss_meta.skip  = i_head.skip;
        iss_meta.last  = last;
        iss_meta.bdone = last && i_head.eob;
        iss_meta.ci    = i_head.skip ? 5'd0 : i_head.base[0][4:0] + 5'(r_ii);
        iss_meta.cj    = (i_head.skip || !multi) ? 5'd0 : i_head.base[1][4:0] + 5'(r_jj);
        iss_meta.ck    = (i_head.skip || !three) ? 5'd0 : i_head.base[2][4:0] + 5'(r_kk);
        w1 = {1'b0, i_head.w[0][r_ii]};
        w2 = multi ? {1'b0, i_head.w[1][r_jj]} : ONE_Q16;
        w3 = three ? {1'b0, i_head.w[2][r_kk]} : ONE_Q16;
    end

    assign o_q_pop = issue && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ii <= '0;
            r_jj <= '0;
            r_kk <= '0;
            r_bv <= '0;
        end else begin
            r_ii <= n_ii;
            r_jj <= n_jj;
            r_kk <= n_kk;
            if (en) begin
                r_bv <= {r_bv[7:1], issue};
            end
        end
    end

    // Weights never exceed one, so the first three products stay in 32 bits.
    assign m1  = 49'(i_head.mass) * 49'(w1);
    assign m2  = 49'(r1_p) * 49'(r1_w2);
    assign m3  = 49'(r2_p) * 49'(r2_w3);
    assign m4  = 64'(r3_p) * 64'(i_cfg.inv[0]);
    // The 48 by 32 products are split into a low and a high partial product.
    assign hp6 = 48'(r5_hi) * 48'(inv_y);
    assign f6  = {hp6, 32'd0} + {16'd0, r5_lo};
    assign hp8 = 48'(r7_hi) * 48'(inv_z);
    assign f8  = {hp8, 32'd0} + {16'd0, r7_lo};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= iss_meta;
            for (int s = 1; s < 8; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
            r1_p   <= m1[47:16];
            r1_w2  <= w2;
            r1_w3  <= w3;
            r2_p   <= m2[47:16];
            r2_w3  <= r1_w3;
            r3_p   <= m3[47:16];
            r4_a   <= m4[63:16];
            r5_lo  <= 64'(r4_a[31:0]) * 64'(inv_y);
            r5_hi  <= r4_a[47:32];
            r6_a   <= f6[63:16];
            r6_sat <= |f6[79:64];
            r7_lo  <= 64'(r6_a[31:0]) * 64'(inv_z);
            r7_hi  <= r6_a[47:32];
            r7_sat <= r6_sat;
            if (r_meta[6].skip) begin
                r8_amt <= '0;
            end else if (r7_sat || (|f8[79:64])) begin
                r8_amt <= AMT_MAX;
            end else begin
                r8_amt <= f8[63:16];
            end
        end
    end

    assign empty         = !r_bv[8];
    assign o_cell_i      = r_meta[7].ci;
    assign o_cell_j      = r_meta[7].cj;
    assign o_cell_k      = r_meta[7].ck;
    assign o_amount      = r8_amt;
    assign o_skipped     = r_meta[7].skip;
    assign o_last_of_run = r_meta[7].last;
    assign o_batch_done  = r_meta[7].bdone;

endmodule

`default_nettype wire

// File: src/tsc_mass_deposit_top.sv
// An item's first result passes the 7 front stages, the job queue and the 8 back
// stages before it reaches the result ports.
// The back end gives one result per cycle while its results are taken; its cell
// sequencer walks 3, 9 or 27 cells per particle (1D/2D/3D), or one when skipped.
// Reset: synchronous, active low; clears valid bits, counters and queue pointers
// and loads the register defaults. No clearing pass is needed.
`default_nettype none

module tsc_mass_deposit_top import tmd_pkg::*; #(
    parameter int CELLS_X = CELLS_X_DEF,
    parameter int CELLS_Y = CELLS_Y_DEF,
    parameter int CELLS_Z = CELLS_Z_DEF,
    parameter int GHOST   = GHOST_DEF,
    parameter int Q_DEPTH = Q_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    // Particle input, queue style.
    input  wire logic                 push,
    output logic                      full,
    input  wire logic        [15:0]   i_block_gid,
    input  wire logic signed [31:0]   i_pos_x,
    input  wire logic signed [31:0]   i_pos_y,
    input  wire logic signed [31:0]   i_pos_z,
    input  wire logic        [31:0]   i_mass,
    input  wire logic                 i_end_of_batch,
    // Cell results, queue style.
    output logic                      empty,
    input  wire logic                 pop,
    output logic [4:0]                o_cell_i,
    output logic [4:0]                o_cell_j,
    output logic [4:0]                o_cell_k,
    output logic [47:0]               o_amount,
    output logic                      o_skipped,
    output logic                      o_last_of_run,
    output logic                      o_batch_done
);

    localparam int OCC_W = $clog2(Q_DEPTH + 1);

    t_cfg             r_cfg;
    logic             accept;
    logic             job_v;
    t_job             job;
    t_job             head;
    t_qstat           q_stat;
    logic             q_pop;
    logic [OCC_W-1:0] r_occ, n_occ;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims   <= 2'd3;
            r_cfg.target <= '0;
            r_cfg.origin <= '0;
            r_cfg.inv    <= {3{INV_RESET}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIMS_MODE:     r_cfg.dims      <= i_cfg_data[1:0];
                CFG_TARGET_BLOCK:  r_cfg.target    <= i_cfg_data[15:0];
                CFG_ORIGIN_X:      r_cfg.origin[0] <= i_cfg_data;
                CFG_ORIGIN_Y:      r_cfg.origin[1] <= i_cfg_data;
                CFG_ORIGIN_Z:      r_cfg.origin[2] <= i_cfg_data;
                CFG_INV_SPACING_X: r_cfg.inv[0]    <= i_cfg_data;
                CFG_INV_SPACING_Y: r_cfg.inv[1]    <= i_cfg_data;
                CFG_INV_SPACING_Z: r_cfg.inv[2]    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front pipeline never stalls. Instead, every item accepted holds a
    // queue slot from acceptance until the back end pops its job, so the queue
    // always has room for whatever arrives from the front.
    assign accept = push && !full;
    assign full   = (r_occ == OCC_W'(Q_DEPTH));
    assign n_occ  = r_occ + OCC_W'(accept) - OCC_W'(q_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    tmd_front #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z),
        .GHOST   (GHOST)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_take         (accept),
        .i_block_gid    (i_block_gid),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_mass         (i_mass),
        .i_end_of_batch (i_end_of_batch),
        .o_job_valid    (job_v),
        .o_job          (job)
    );

    tmd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_v),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // The back end issues one cell per cycle into its multiply pipeline and
    // holds the whole pipeline only while the result register is not taken.
    tmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .i_q_empty     (q_stat.empty),
        .o_q_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .o_cell_i      (o_cell_i),
        .o_cell_j      (o_cell_j),
        .o_cell_k      (o_cell_k),
        .o_amount      (o_amount),
        .o_skipped     (o_skipped),
        .o_last_of_run (o_last_of_run),
        .o_batch_done  (o_batch_done)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(Q_DEPTH))
        else $error("outstanding item count exceeds the queue depth");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_v |-> !q_stat.full)
        else $error("front end delivered a job into a full queue");

    a_skip_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_skipped) |-> (o_amount == '0 && o_last_of_run))
        else $error("skipped result carries an amount or is not last");

    a_batch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_batch_done) |-> o_last_of_run)
        else $error("batch_done set on a result that is not last of its run");
`endif

endmodule

`default_nettype wire
